// ===== hdl/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int WORD_W       = 32;
	localparam int LEN_W        = 64;
	localparam int FIFO_DEPTH_D = 4;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// One message word handed from the front to the compression engine
	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic              blk_end;
		logic              msg_end;
	} word_req_t;

	function automatic logic [WORD_W-1:0] iv_at(input logic [2:0] i);
		logic [WORD_W-1:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] k_at(input logic [5:0] t);
		logic [WORD_W-1:0] r;
		case (t)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
		input int n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] sig0(input logic [WORD_W-1:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [WORD_W-1:0] sig1(input logic [WORD_W-1:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [WORD_W-1:0] big0(input logic [WORD_W-1:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [WORD_W-1:0] big1(input logic [WORD_W-1:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

// ===== hdl/sha_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, byte_value, byte_present, end_of_message, input ready);
	modport sink   (input valid, byte_value, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hdl/sha_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_fifo
// Short word queue between the byte front end and the compression engine.
// ----------------------------------------------------------------------------
module sha_fifo import sha_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_D
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  word_req_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output word_req_t pop_data
);
	localparam int PW = $clog2(DEPTH);

	word_req_t     mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full      = (cnt_q == (PW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	// store requests
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== hdl/sha_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_front
// Packs message bytes into words, counts length and generates the padding.
// ----------------------------------------------------------------------------
module sha_front import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sha_in_if.sink    in_ch,
	output logic      push,
	output word_req_t push_data,
	input  logic      full
);
	typedef enum logic [1:0] {
		ST_ACCEPT = 2'b01,
		ST_PAD    = 2'b10
	} fst_t;

	fst_t             st_q;
	logic [23:0]      acc_q;
	logic [5:0]       fill_q;
	logic [LEN_W-1:0] len_q;
	logic             first_q;
	logic             final_q;
	logic [3:0]       wi_q;

	logic             take, byte_push, pad_push, final_w;
	logic [3:0]       wi;
	logic [WORD_W-1:0] pad_word;

	assign in_ch.ready = (st_q == ST_ACCEPT) && !full;
	assign take        = in_ch.valid && in_ch.ready;
	assign byte_push   = take && in_ch.byte_present && (fill_q[1:0] == 2'd3);
	assign pad_push    = (st_q == ST_PAD) && !full;
	assign final_w     = first_q ? (fill_q < 6'd56) : final_q;
	assign wi          = first_q ? fill_q[5:2] : wi_q;

	// padding word: merge 0x80 after the gathered bytes, zeros, then length
	always_comb begin
		pad_word = '0;
		if (first_q) begin
			case (fill_q[1:0])
				2'd0:    pad_word = {PAD_BYTE, 24'h0};
				2'd1:    pad_word = {acc_q[7:0], PAD_BYTE, 16'h0};
				2'd2:    pad_word = {acc_q[15:0], PAD_BYTE, 8'h0};
				default: pad_word = {acc_q[23:0], PAD_BYTE};
			endcase
		end else if (final_q && wi_q == 4'd14) begin
			pad_word = len_q[LEN_W-1:WORD_W];
		end else if (final_q && wi_q == 4'd15) begin
			pad_word = len_q[WORD_W-1:0];
		end
	end

	// select the request toward the queue
	always_comb begin
		push = byte_push || pad_push;
		if (pad_push) begin
			push_data.data    = pad_word;
			push_data.blk_end = (wi == 4'd15);
			push_data.msg_end = (wi == 4'd15) && final_w;
		end else begin
			push_data.data    = {acc_q, in_ch.byte_value};
			push_data.blk_end = (fill_q == 6'd63);
			push_data.msg_end = 1'b0;
		end
	end

	// gather bytes, then walk the padding words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_ACCEPT;
			acc_q   <= '0;
			fill_q  <= '0;
			len_q   <= '0;
			first_q <= 1'b0;
			final_q <= 1'b0;
			wi_q    <= '0;
		end else begin
			case (st_q)
				ST_ACCEPT: begin
					if (take) begin
						if (in_ch.byte_present) begin
							acc_q  <= {acc_q[15:0], in_ch.byte_value};
							fill_q <= fill_q + 1'b1;
							len_q  <= len_q + LEN_W'(8);
						end
						if (in_ch.end_of_message) begin
							st_q    <= ST_PAD;
							first_q <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					if (pad_push) begin
						first_q <= 1'b0;
						final_q <= (wi == 4'd15) ? 1'b1 : final_w;
						wi_q    <= wi + 1'b1;
						if (push_data.msg_end) begin
							st_q   <= ST_ACCEPT;
							fill_q <= '0;
							len_q  <= '0;
						end
					end
				end
				default: st_q <= ST_ACCEPT;
			endcase
		end
	end
endmodule

// ===== hdl/sha_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_back
// Compression engine: one round per cycle when fed, rolling schedule, digest.
// ----------------------------------------------------------------------------
module sha_back import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      not_empty,
	input  word_req_t pop_data,
	output logic      pop,
	sha_out_if.source out_ch
);
	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_FOLD  = 4'b0100,
		ST_EMIT  = 4'b1000
	} bst_t;

	bst_t              st_q;
	logic [5:0]        t_q;
	logic              msg_q;
	logic [2:0]        cnt_q;
	logic [WORD_W-1:0] h_q [8];
	logic [WORD_W-1:0] v_q [8];
	logic [WORD_W-1:0] w_q [16];
	logic              ov_q;
	logic [WORD_W-1:0] dw_q;
	logic [2:0]        idx_q;
	logic              last_q;

	logic              step, load_out;
	logic [WORD_W-1:0] w_new, wt, t1, t2, chv, mjv;

	assign pop      = (st_q == ST_LOAD) && not_empty;
	assign step     = pop || (st_q == ST_ROUND);
	assign load_out = (st_q == ST_EMIT) && (!ov_q || out_ch.ready);

	// schedule word and round terms
	always_comb begin
		w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
		wt    = (st_q == ST_LOAD) ? pop_data.data : w_new;
		chv   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		mjv   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + big1(v_q[4]) + chv + k_at(t_q) + wt;
		t2    = big0(v_q[0]) + mjv;
	end

	assign out_ch.valid       = ov_q;
	assign out_ch.digest_word = dw_q;
	assign out_ch.word_index  = idx_q;
	assign out_ch.last_word   = last_q;

	// round sequencer, chaining update and digest readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_LOAD;
			t_q    <= '0;
			msg_q  <= 1'b0;
			cnt_q  <= '0;
			ov_q   <= 1'b0;
			dw_q   <= '0;
			idx_q  <= '0;
			last_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= iv_at(3'(i));
				v_q[i] <= iv_at(3'(i));
			end
		end else begin
			if (ov_q && out_ch.ready && !load_out) ov_q <= 1'b0;
			if (step) begin
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
				t_q    <= t_q + 1'b1;
			end
			case (st_q)
				ST_LOAD: begin
					if (pop && t_q == 6'd15) begin
						st_q  <= ST_ROUND;
						msg_q <= pop_data.msg_end;
					end
				end
				ST_ROUND: begin
					if (t_q == 6'd63) st_q <= ST_FOLD;
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
						v_q[i] <= h_q[i] + v_q[i];
					end
					cnt_q <= '0;
					st_q  <= msg_q ? ST_EMIT : ST_LOAD;
				end
				ST_EMIT: begin
					if (load_out) begin
						ov_q   <= 1'b1;
						dw_q   <= h_q[0];
						idx_q  <= cnt_q;
						last_q <= (cnt_q == 3'd7);
						cnt_q  <= cnt_q + 1'b1;
						if (cnt_q == 3'd7) begin
							st_q <= ST_LOAD;
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= iv_at(3'(i));
								v_q[i] <= iv_at(3'(i));
							end
						end else begin
							for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
							h_q[7] <= h_q[0];
						end
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	// rolling 16-word schedule window
	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
		end
	end
endmodule

// ===== hdl/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 of a byte stream, digest delivered as eight 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per message byte (byte_present) and marks the
//   last request with end_of_message; a request may carry only the end mark.
//   out_ch delivers eight digest words, word_index 0 first, last_word on 7.
// Timing:
//   The front takes at most one byte per cycle, packs four bytes into a word
//   and queues it (four words); the engine runs rounds 0-15 as words arrive,
//   then rounds 16-63 and the fold step. The queue holds only 16 bytes of
//   the next block while those run, so on a long message byte intake
//   stalls behind the tail rounds of each block. An end request adds
//   padding of one or two blocks, then the eight words leave one per cycle
//   while out_ch.ready is high.
// Reset:
//   arst_n clears the length, byte count and queue and loads the initial
//   hash values; the block accepts requests as soon as arst_n is released.
// Stalls:
//   When out_ch.ready is low the current word holds; the engine waits,
//   the queue fills and in_ch.ready then drops.
// ----------------------------------------------------------------------------
module sha256_stream_hasher import sha_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_D
) (
	input  logic      clk,
	input  logic      arst_n,
	sha_in_if.sink    in_ch,
	sha_out_if.source out_ch
);
	logic      push, full, pop, not_empty;
	word_req_t push_data, pop_data;

	sha_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	sha_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	sha_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_ch    (out_ch)
	);
endmodule

// ===== hdl/sha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the digest word sequence.
// ----------------------------------------------------------------------------
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);
	// last flag marks word seven only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word does not match word_index");

	// words of one digest leave back to back in order
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=>
		(out_valid && word_index == 3'($past(word_index) + 3'd1)))
		else $error("digest word sequence broken");

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(digest_word)))
		else $error("stalled digest word changed");
endmodule

bind sha256_stream_hasher sha_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.digest_word (out_ch.digest_word),
	.word_index  (out_ch.word_index),
	.last_word   (out_ch.last_word)
);
